[hw/rtl/tym_pkg.sv]
// ---------------------------------------------------------------------------
// tym_pkg: shared types and constants for the two-thruster yaw mixer
// Holds command codes, register indexes, pulse limits and the interface
// struct between the mixer and its serial gain divider.
// ---------------------------------------------------------------------------
`default_nettype none

package tym_pkg;

  // Command codes carried in the action field.
  localparam logic [3:0] ACT_ALL       = 4'd0;
  localparam logic [3:0] ACT_PORT      = 4'd1;
  localparam logic [3:0] ACT_VERTICAL  = 4'd2;
  localparam logic [3:0] ACT_STARBOARD = 4'd3;
  localparam logic [3:0] ACT_THROTTLE  = 4'd4;
  localparam logic [3:0] ACT_YAW       = 4'd5;
  localparam logic [3:0] ACT_LIFT      = 4'd6;
  localparam logic [3:0] ACT_STOP      = 4'd7;
  localparam logic [3:0] ACT_TICK      = 4'd8;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W    = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FWD_GAIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REV_GAIN = 2'd1;

  localparam logic [7:0] GAIN_RESET = 8'd100;
  localparam logic [7:0] GAIN_LO    = 8'd50;
  localparam logic [7:0] GAIN_HI    = 8'd200;

  // Mixing arithmetic is done on 14-bit signed values.
  localparam logic signed [13:0] MIX_MID   = 14'sd1500;
  localparam logic signed [13:0] PULSE_MIN = 14'sd1000;
  localparam logic signed [13:0] PULSE_MAX = 14'sd2000;
  localparam logic signed [13:0] LIFT_STEP = 14'sd5;

  // Window for direct pulse commands (exclusive bounds).
  localparam logic signed [11:0] PULSE_WIN_LO = 12'sd999;
  localparam logic signed [11:0] PULSE_WIN_HI = 12'sd2001;
  localparam logic signed [11:0] PCT_MAX      = 12'sd100;
  localparam logic signed [11:0] PCT_MIN      = -12'sd100;

  localparam logic [15:0] THROTTLE_SPAN = 16'd500;

  // Divide by five as multiply by 205 and shift by 10, exact for 0..1023.
  localparam logic [17:0] DIV5_RECIP = 18'd205;
  localparam logic [11:0] FWD_ORIGIN = 12'd1000;
  localparam logic [8:0]  FWD_OFFSET = 9'd100;

  // Serial divider geometry.
  localparam int unsigned DIV_NUM_W = 16;
  localparam int unsigned DIV_DEN_W = 8;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quot;
    logic [DIV_DEN_W-1:0] rem;
  } tym_div_res_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_EMIT
  } tym_state_t;

  function automatic logic pulse_ok(input logic signed [11:0] v);
    return (v > PULSE_WIN_LO) && (v < PULSE_WIN_HI);
  endfunction

  function automatic logic pct_ok(input logic signed [11:0] v);
    return (v >= PCT_MIN) && (v <= PCT_MAX);
  endfunction

endpackage

`default_nettype wire

[hw/rtl/tym_div.sv]
// ---------------------------------------------------------------------------
// tym_div: bit-serial restoring divider
// Divides an unsigned numerator by an unsigned divisor, one quotient bit per
// cycle, and pulses done when quotient and remainder are ready.
// ---------------------------------------------------------------------------
`default_nettype none

module tym_div
  import tym_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [DIV_NUM_W-1:0] num,
  input  wire logic [DIV_DEN_W-1:0] den,
  output tym_div_res_t              res
);

  localparam int unsigned CNT_W = $clog2(DIV_NUM_W);

  logic                 busy_r;
  logic                 done_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [DIV_NUM_W-1:0] num_r;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_DEN_W-1:0] rem_r;

  logic [DIV_DEN_W:0]   rem_sh;
  logic [DIV_DEN_W:0]   rem_dif;
  logic                 ge;
  logic                 last;

  always_comb begin
    rem_sh  = {rem_r, num_r[DIV_NUM_W-1]};
    rem_dif = rem_sh - {1'b0, den_r};
    ge      = rem_sh >= {1'b0, den_r};
    last    = busy_r && (cnt_r == CNT_W'(DIV_NUM_W - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= last;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (last) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // The numerator register shifts out dividend bits and takes in quotient bits.
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[DIV_NUM_W-2:0], ge};
      rem_r <= ge ? rem_dif[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
    end
  end

  assign res.done = done_r;
  assign res.quot = num_r;
  assign res.rem  = rem_r;

endmodule

`default_nettype wire

[hw/rtl/two_thruster_yaw_mixer.sv]
// ---------------------------------------------------------------------------
// two_thruster_yaw_mixer: differential thrust mixer for three thrusters
// Takes pulse and percent commands, mixes throttle and yaw into the port and
// starboard pair, and reports the applied pulses once per command.
// ---------------------------------------------------------------------------
// Every accepted command yields exactly one result transaction. Throttle and
// yaw commands run the gain division on a bit-serial divider that retires one
// quotient bit per cycle over 16 bits; every other command skips the divider.
// One command is in flight at a time and in_tready is high whenever the mixer
// is idle, even if the previous result still sits in the output register.
// Gains are to be written through the cfg port only while no command is in
// flight; the mixer itself does not enforce this. Values outside 50..200 act
// as the nearest bound.
`default_nettype none

module two_thruster_yaw_mixer
  import tym_pkg::*;
#(
  parameter int unsigned NEUTRAL_US = 1500
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // Fields from bit 0: action[3:0], value_a[15:4], value_b[27:16],
  // value_c[39:28].
  input  wire logic [39:0]          in_tdata,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  // Fields from bit 0: port_pulse[11:0], vertical_pulse[23:12],
  // starboard_pulse[35:24], motors_active[36], outputs_updated[37],
  // forward_thrust_pct[46:38], zero pad[47].
  output logic [47:0]               out_tdata,
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data
);

  localparam logic [11:0] NEUTRAL = 12'(NEUTRAL_US);

  // Input fields.
  logic [3:0]         in_action;
  logic signed [11:0] in_a;
  logic signed [11:0] in_b;
  logic signed [11:0] in_c;

  assign in_action = in_tdata[3:0];
  assign in_a      = in_tdata[15:4];
  assign in_b      = in_tdata[27:16];
  assign in_c      = in_tdata[39:28];

  tym_state_t         state_r, state_nxt;
  logic [7:0]         fwd_gain_r;
  logic [7:0]         rev_gain_r;
  logic [3:0]         act_r;
  logic signed [11:0] a_r, b_r, c_r;
  logic signed [7:0]  throttle_r;
  logic signed [7:0]  yaw_r;
  logic [2:0][11:0]   tgt_r, tgt_nxt;
  logic [2:0][11:0]   app_r, app_nxt;
  logic               active_r, active_nxt;

  logic               out_valid_r;
  logic [11:0]        out_port_r, out_vert_r, out_stbd_r;
  logic               out_active_r, out_upd_r;

  logic               in_fire;
  logic               emit_ok;
  logic               load_out;
  logic               upd;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign emit_ok   = !out_valid_r || out_tready;
  assign cfg_ready = 1'b1;

  // ---------------- divider launch ----------------
  logic                 div_start;
  logic signed [7:0]    t_new;
  logic [7:0]           t_abs;
  logic [7:0]           gain_raw;
  logic [7:0]           gain_sat;
  logic [DIV_NUM_W-1:0] div_num;
  tym_div_res_t         div_res;

  always_comb begin
    div_start = in_fire && ((in_action == ACT_THROTTLE) || (in_action == ACT_YAW));
    t_new     = ((in_action == ACT_THROTTLE) && pct_ok(in_a)) ? in_a[7:0] : throttle_r;
    t_abs     = t_new[7] ? 8'(-t_new) : 8'(t_new);
    gain_raw  = t_new[7] ? rev_gain_r : fwd_gain_r;
    if (gain_raw < GAIN_LO) begin
      gain_sat = GAIN_LO;
    end else if (gain_raw > GAIN_HI) begin
      gain_sat = GAIN_HI;
    end else begin
      gain_sat = gain_raw;
    end
    div_num = DIV_NUM_W'(t_abs) * THROTTLE_SPAN;
  end

  tym_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (gain_sat),
    .res   (div_res)
  );

  // ---------------- remix arithmetic ----------------
  logic               thr_neg;
  logic [13:0]        q_ext;
  logic signed [13:0] base;
  logic [7:0]         yaw_abs;
  logic [8:0]         yaw_x5;
  logic signed [13:0] turn_mag;
  logic signed [13:0] turn;
  logic signed [13:0] off;
  logic signed [13:0] port_v;
  logic signed [13:0] stbd_v;
  logic signed [13:0] lift_v;

  always_comb begin
    thr_neg = throttle_r[7];
    // Floor division: a negative quotient with a remainder steps down by one.
    q_ext   = 14'(div_res.quot[10:0]) + 14'(thr_neg && (|div_res.rem));
    base    = thr_neg ? (MIX_MID - $signed(q_ext)) : (MIX_MID + $signed(q_ext));
    yaw_abs = yaw_r[7] ? 8'(-yaw_r) : 8'(yaw_r);
    yaw_x5  = 9'(yaw_abs) * 9'd5;
    turn_mag = $signed(14'(yaw_x5[8:1]));
    turn     = yaw_r[7] ? -turn_mag : turn_mag;
    if (!thr_neg) begin
      off = turn_mag + base - PULSE_MAX;
      if (off < 0) begin
        off = '0;
      end
      port_v = base + turn - off;
      stbd_v = base - turn - off;
    end else begin
      off = PULSE_MIN - (base - turn_mag);
      if (off < 0) begin
        off = '0;
      end
      port_v = base + turn + off;
      stbd_v = base - turn + off;
    end
    lift_v = MIX_MID + $signed({{2{a_r[11]}}, a_r}) * LIFT_STEP;
  end

  // ---------------- control ----------------
  always_comb begin
    state_nxt  = state_r;
    tgt_nxt    = tgt_r;
    app_nxt    = app_r;
    active_nxt = active_r;
    upd        = 1'b0;
    load_out   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = div_start ? S_DIV : S_EMIT;
        end
      end
      S_DIV: begin
        if (div_res.done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (emit_ok) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
          case (act_r)
            ACT_ALL: begin
              if (pulse_ok(a_r) && pulse_ok(b_r) && pulse_ok(c_r)) begin
                tgt_nxt[0] = a_r;
                tgt_nxt[1] = b_r;
                tgt_nxt[2] = c_r;
              end
            end
            ACT_PORT: begin
              if (pulse_ok(a_r)) tgt_nxt[0] = a_r;
            end
            ACT_VERTICAL: begin
              if (pulse_ok(a_r)) tgt_nxt[1] = a_r;
            end
            ACT_STARBOARD: begin
              if (pulse_ok(a_r)) tgt_nxt[2] = a_r;
            end
            ACT_THROTTLE, ACT_YAW: begin
              tgt_nxt[0] = port_v[11:0];
              tgt_nxt[2] = stbd_v[11:0];
            end
            ACT_LIFT: begin
              if (pct_ok(a_r)) tgt_nxt[1] = lift_v[11:0];
            end
            ACT_STOP: begin
              tgt_nxt = {3{NEUTRAL}};
            end
            ACT_TICK: begin
              if (tgt_r != app_r) begin
                app_nxt    = tgt_r;
                active_nxt = (tgt_r[0] != NEUTRAL) || (tgt_r[1] != NEUTRAL) ||
                             (tgt_r[2] != NEUTRAL);
                upd        = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fwd_gain_r  <= GAIN_RESET;
      rev_gain_r  <= GAIN_RESET;
      throttle_r  <= '0;
      yaw_r       <= '0;
      tgt_r       <= {3{NEUTRAL}};
      app_r       <= {3{NEUTRAL}};
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      tgt_r    <= tgt_nxt;
      app_r    <= app_nxt;
      active_r <= active_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_FWD_GAIN: fwd_gain_r <= cfg_data;
          CFG_REV_GAIN: rev_gain_r <= cfg_data;
          default: begin
          end
        endcase
      end
      // Percents are stored at acceptance so the remix arithmetic sees the new value.
      if (in_fire && pct_ok(in_a)) begin
        if (in_action == ACT_THROTTLE) throttle_r <= in_a[7:0];
        if (in_action == ACT_YAW)      yaw_r      <= in_a[7:0];
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      act_r <= in_action;
      a_r   <= in_a;
      b_r   <= in_b;
      c_r   <= in_c;
    end
    if (load_out) begin
      out_port_r   <= app_nxt[0];
      out_vert_r   <= app_nxt[1];
      out_stbd_r   <= app_nxt[2];
      out_active_r <= active_nxt;
      out_upd_r    <= upd;
    end
  end

  // ---------------- forward thrust ----------------
  // Applied pulses stay in 1000..2000, so the mean offset fits ten bits.
  logic [12:0] pair_sum;
  logic [11:0] mean;
  logic [11:0] mean_off;
  logic [17:0] fwd_prod;
  logic [8:0]  fwd_pct;

  always_comb begin
    pair_sum = {1'b0, out_port_r} + {1'b0, out_stbd_r};
    mean     = pair_sum[12:1];
    mean_off = mean - FWD_ORIGIN;
    fwd_prod = 18'(mean_off[9:0]) * DIV5_RECIP;
    fwd_pct  = {1'b0, fwd_prod[17:10]} - FWD_OFFSET;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, fwd_pct, out_upd_r, out_active_r,
                       out_stbd_r, out_vert_r, out_port_r};

endmodule

`default_nettype wire

[hw/rtl/tym_checker.sv]
// ---------------------------------------------------------------------------
// tym_checker: port-level checks for the two-thruster yaw mixer
// Watches the result channel and checks output holding, pulse limits and
// the consistency of the motors-active flag.
// ---------------------------------------------------------------------------
`default_nettype none

module tym_checker #(
  parameter int unsigned NEUTRAL_US = 1500
) (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic [47:0] out_tdata,
  input wire logic        out_tvalid,
  input wire logic        out_tready
);

  localparam logic [11:0] NEUTRAL = 12'(NEUTRAL_US);
  localparam logic [11:0] P_MIN   = 12'd1000;
  localparam logic [11:0] P_MAX   = 12'd2000;

  logic [11:0] port_p, vert_p, stbd_p;
  logic        active;

  assign port_p = out_tdata[11:0];
  assign vert_p = out_tdata[23:12];
  assign stbd_p = out_tdata[35:24];
  assign active = out_tdata[36];

  // A stalled result transaction keeps its contents.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Applied pulses never leave the legal window.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (port_p >= P_MIN) && (port_p <= P_MAX) &&
                   (vert_p >= P_MIN) && (vert_p <= P_MAX) &&
                   (stbd_p >= P_MIN) && (stbd_p <= P_MAX))
    else $error("applied pulse out of range");

  // The active flag always reflects the applied pulses it reports with.
  a_active: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> active == ((port_p != NEUTRAL) || (vert_p != NEUTRAL) ||
                              (stbd_p != NEUTRAL)))
    else $error("motors_active disagrees with applied pulses");

endmodule

bind two_thruster_yaw_mixer tym_checker #(.NEUTRAL_US(NEUTRAL_US)) u_tym_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

`default_nettype wire

[tb/thrust_mix_checker.sv]
// ---------------------------------------------------------------------------
// thrust_mix_checker: scoreboard for the two-thruster yaw mixer
// Watches the command, result and gain-write channels, keeps its own copy of
// the mixer state and gains, predicts one report per accepted command and
// compares every delivered report field by field against the oldest one.
// ---------------------------------------------------------------------------
`default_nettype none

module thrust_mix_checker
  import tym_pkg::*;
#(
  parameter int NEUTRAL = 1500
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [39:0]          in_tdata,
  input  wire logic                 in_tvalid,
  input  wire logic                 in_tready,
  input  wire logic [47:0]          out_tdata,
  input  wire logic                 out_tvalid,
  input  wire logic                 out_tready,
  input  wire logic                 cfg_valid,
  input  wire logic                 cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data,
  output int                        pending,
  output int                        fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  // Laid out from the top bit down so that it overlays out_tdata[46:0].
  typedef struct packed {
    logic [8:0]  fwd;
    logic        updated;
    logic        active;
    logic [11:0] stbd;
    logic [11:0] vert;
    logic [11:0] port;
  } pulse_report_t;

  int            target[3];
  int            applied[3];
  int            thr_pct;
  int            yaw_pct;
  logic          active;
  logic [7:0]    fwd_gain;
  logic [7:0]    rev_gain;
  int            errs;
  pulse_report_t expected_reports[$];

  function automatic bit pulse_in_window(input int v);
    return v > 999 && v < 2001;
  endfunction

  function automatic bit pct_in_range(input int v);
    return v >= -100 && v <= 100;
  endfunction

  function automatic int clamp_gain(input logic [7:0] g);
    if (g < 8'd50) return 50;
    if (g > 8'd200) return 200;
    return int'(g);
  endfunction

  // Recomputes the port/starboard targets from the stored percents.
  function automatic void remix_pair();
    int gain, num, base, turn, mag, off;
    gain = clamp_gain(thr_pct >= 0 ? fwd_gain : rev_gain);
    num  = 500 * thr_pct;
    base = num / gain;
    // Round toward minus infinity, not toward zero.
    if (num % gain != 0 && num < 0) base = base - 1;
    base = 1500 + base;
    turn = (5 * yaw_pct) / 2;
    mag  = turn < 0 ? -turn : turn;
    if (thr_pct >= 0) begin
      off = mag + base - 2000;
      if (off < 0) off = 0;
      target[0] = base + turn - off;
      target[2] = base - turn - off;
    end else begin
      off = 1000 - (base - mag);
      if (off < 0) off = 0;
      target[0] = base + turn + off;
      target[2] = base - turn + off;
    end
  endfunction

  function automatic pulse_report_t mix_command(input logic [3:0] act, input int a,
                                                input int b, input int c);
    pulse_report_t rpt;
    int mean, fwd;
    rpt.updated = 1'b0;
    case (act)
      ACT_ALL: begin
        if (pulse_in_window(a) && pulse_in_window(b) && pulse_in_window(c)) begin
          target[0] = a;
          target[1] = b;
          target[2] = c;
        end
      end
      ACT_PORT:      if (pulse_in_window(a)) target[0] = a;
      ACT_VERTICAL:  if (pulse_in_window(a)) target[1] = a;
      ACT_STARBOARD: if (pulse_in_window(a)) target[2] = a;
      ACT_THROTTLE: begin
        if (pct_in_range(a)) thr_pct = a;
        remix_pair();
      end
      ACT_YAW: begin
        if (pct_in_range(a)) yaw_pct = a;
        remix_pair();
      end
      ACT_LIFT: if (pct_in_range(a)) target[1] = 1500 + 5 * a;
      ACT_STOP: begin
        for (int i = 0; i < 3; i++) target[i] = NEUTRAL;
      end
      ACT_TICK: begin
        if (target[0] != applied[0] || target[1] != applied[1] ||
            target[2] != applied[2]) begin
          for (int i = 0; i < 3; i++) applied[i] = target[i];
          active = applied[0] != NEUTRAL || applied[1] != NEUTRAL ||
                   applied[2] != NEUTRAL;
          rpt.updated = 1'b1;
        end
      end
      default: ;
    endcase
    mean = (applied[0] + applied[2]) / 2;
    fwd  = (mean - 1000) * 200 / 1000 - 100;
    rpt.port   = applied[0][11:0];
    rpt.vert   = applied[1][11:0];
    rpt.stbd   = applied[2][11:0];
    rpt.active = active;
    rpt.fwd    = fwd[8:0];
    return rpt;
  endfunction

  task automatic check_field(input string fname, input int want, input int got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
      errs++;
    end
  endtask

  always @(posedge clk) begin : watch
    pulse_report_t got, want;
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        target[i]  = NEUTRAL;
        applied[i] = NEUTRAL;
      end
      thr_pct  = 0;
      yaw_pct  = 0;
      active   = 1'b0;
      fwd_gain = GAIN_RESET;
      rev_gain = GAIN_RESET;
      expected_reports.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_FWD_GAIN: fwd_gain = cfg_data;
          CFG_REV_GAIN: rev_gain = cfg_data;
          default: ;
        endcase
      end
      // Results are retired before the command of this edge is added, so a
      // report is never matched against a command accepted at the same edge.
      if (out_tvalid && out_tready) begin
        got = out_tdata[46:0];
        if (expected_reports.size() == 0) begin
          $display("%0t ns: report with no command pending, expected none, got %h",
                   $time, out_tdata);
          errs++;
        end else begin
          want = expected_reports.pop_front();
          check_field("port_pulse", want.port, got.port);
          check_field("vertical_pulse", want.vert, got.vert);
          check_field("starboard_pulse", want.stbd, got.stbd);
          check_field("motors_active", want.active, got.active);
          check_field("outputs_updated", want.updated, got.updated);
          check_field("forward_thrust_pct", $signed(want.fwd), $signed(got.fwd));
        end
      end
      if (in_tvalid && in_tready)
        expected_reports.push_back(mix_command(in_tdata[3:0], $signed(in_tdata[15:4]),
                                               $signed(in_tdata[27:16]),
                                               $signed(in_tdata[39:28])));
    end
    pending    <= expected_reports.size();
    fail_count <= errs;
  end

  initial errs = 0;

endmodule

`default_nettype wire

[tb/tb.sv]
// ---------------------------------------------------------------------------
// tb: stimulus and verdict for the two-thruster yaw mixer
// Resets the mixer, runs a directed command sequence and then phases of
// weighted random commands under several gain settings and handshake idling
// patterns, while the checker scores every report.
// ---------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tym_pkg::*;

  localparam logic [3:0] ACT_UNUSED_FIRST = 4'd9;
  localparam logic [3:0] ACT_UNUSED_LAST  = 4'd15;
  localparam int         PHASE_ITEMS      = 135;

  logic                 clk;
  logic                 rst_n;
  logic [39:0]          in_tdata;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [47:0]          out_tdata;
  logic                 out_tvalid;
  logic                 out_tready;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0]           cfg_data;
  int                   pending;
  int                   fail_count;
  int                   in_gap_pct;
  int                   out_stall_pct;

  two_thruster_yaw_mixer uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  thrust_mix_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pending    (pending),
    .fail_count (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= (out_stall_pct == 0) || ($urandom_range(99) >= out_stall_pct);
  end

  function automatic int raw12();
    return int'($urandom_range(4095)) - 2048;
  endfunction

  function automatic int rand_pulse();
    int r;
    r = $urandom_range(99);
    if (r < 60) return int'($urandom_range(2000, 1000));
    if (r < 75) begin
      case ($urandom_range(3))
        0: return 999;
        1: return 1000;
        2: return 2000;
        default: return 2001;
      endcase
    end
    return raw12();
  endfunction

  function automatic int rand_pct();
    int r;
    r = $urandom_range(99);
    if (r < 70) return int'($urandom_range(200)) - 100;
    if (r < 80) begin
      case ($urandom_range(3))
        0: return -101;
        1: return -100;
        2: return 100;
        default: return 101;
      endcase
    end
    return raw12();
  endfunction

  task automatic send_cmd(input logic [3:0] act, input int a, input int b, input int c);
    while (in_gap_pct != 0 && $urandom_range(99) < in_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tdata  <= {c[11:0], b[11:0], a[11:0], act};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_random_cmd();
    int         r;
    logic [3:0] act;
    r = $urandom_range(99);
    if (r < 12) begin
      send_cmd(ACT_ALL, rand_pulse(), rand_pulse(), rand_pulse());
    end else if (r < 24) begin
      case ($urandom_range(2))
        0: act = ACT_PORT;
        1: act = ACT_VERTICAL;
        default: act = ACT_STARBOARD;
      endcase
      send_cmd(act, rand_pulse(), raw12(), raw12());
    end else if (r < 40) begin
      send_cmd(ACT_THROTTLE, rand_pct(), raw12(), raw12());
    end else if (r < 55) begin
      send_cmd(ACT_YAW, rand_pct(), raw12(), raw12());
    end else if (r < 63) begin
      send_cmd(ACT_LIFT, rand_pct(), raw12(), raw12());
    end else if (r < 67) begin
      send_cmd(ACT_STOP, raw12(), raw12(), raw12());
    end else if (r < 95) begin
      send_cmd(ACT_TICK, raw12(), raw12(), raw12());
    end else begin
      act = 4'($urandom_range(ACT_UNUSED_LAST, ACT_UNUSED_FIRST));
      send_cmd(act, raw12(), raw12(), raw12());
    end
  endtask

  // Lets the mixer go idle: every command has exactly one report.
  task automatic drain_commands();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_gain(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_tdata      <= '0;
    in_tvalid     <= 1'b0;
    out_tready    <= 1'b0;
    cfg_valid     <= 1'b0;
    cfg_index     <= CFG_FWD_GAIN;
    cfg_data      <= '0;
    in_gap_pct    = 0;
    out_stall_pct = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed sequence: window edges, percent limits, stop and idle ticks.
    send_cmd(ACT_TICK, 0, 0, 0);
    send_cmd(ACT_ALL, 1000, 1000, 2000);
    send_cmd(ACT_ALL, 999, 1500, 1500);
    send_cmd(ACT_ALL, 1500, 2001, 1500);
    send_cmd(ACT_TICK, 0, 0, 0);
    send_cmd(ACT_PORT, 2000, 0, 0);
    send_cmd(ACT_VERTICAL, 1000, 0, 0);
    send_cmd(ACT_STARBOARD, 999, 0, 0);
    send_cmd(ACT_STARBOARD, 2047, -2048, 2047);
    send_cmd(ACT_PORT, -2048, 2047, -2048);
    send_cmd(ACT_TICK, 0, 0, 0);
    send_cmd(ACT_THROTTLE, 100, 0, 0);
    send_cmd(ACT_YAW, 100, 0, 0);
    send_cmd(ACT_TICK, 0, 0, 0);
    send_cmd(ACT_THROTTLE, -100, 0, 0);
    send_cmd(ACT_YAW, -100, 0, 0);
    send_cmd(ACT_TICK, 0, 0, 0);
    send_cmd(ACT_THROTTLE, 101, 0, 0);
    send_cmd(ACT_YAW, -101, 0, 0);
    send_cmd(ACT_LIFT, 100, 0, 0);
    send_cmd(ACT_LIFT, -101, 0, 0);
    send_cmd(ACT_LIFT, -100, 0, 0);
    send_cmd(ACT_TICK, 0, 0, 0);
    send_cmd(ACT_STOP, 0, 0, 0);
    send_cmd(ACT_TICK, 0, 0, 0);
    send_cmd(ACT_UNUSED_LAST, -1, -1, -1);

    for (int ph = 0; ph < 8; ph++) begin
      drain_commands();
      case (ph)
        1: begin
          write_gain(CFG_FWD_GAIN, 8'd50);
          write_gain(CFG_REV_GAIN, 8'd200);
        end
        2: begin
          write_gain(CFG_FWD_GAIN, 8'd200);
          write_gain(CFG_REV_GAIN, 8'd50);
        end
        3: begin
          write_gain(CFG_FWD_GAIN, 8'd0);
          write_gain(CFG_REV_GAIN, 8'd255);
        end
        4: begin
          write_gain(CFG_FWD_GAIN, 8'd255);
          write_gain(CFG_REV_GAIN, 8'd0);
        end
        5: begin
          write_gain(CFG_FWD_GAIN, 8'd49);
          write_gain(CFG_REV_GAIN, 8'd201);
        end
        6: begin
          write_gain(CFG_FWD_GAIN, 8'($urandom_range(255)));
          write_gain(CFG_REV_GAIN, 8'($urandom_range(255)));
        end
        7: begin
          write_gain(CFG_FWD_GAIN, 8'd100);
          write_gain(CFG_REV_GAIN, 8'd100);
        end
        default: ;
      endcase
      case (ph % 4)
        1: begin
          in_gap_pct    = 51;
          out_stall_pct = 0;
        end
        2: begin
          in_gap_pct    = 0;
          out_stall_pct = 51;
        end
        3: begin
          in_gap_pct    = 29;
          out_stall_pct = 29;
        end
        default: begin
          in_gap_pct    = 0;
          out_stall_pct = 0;
        end
      endcase
      repeat (PHASE_ITEMS) send_random_cmd();
    end

    drain_commands();
    repeat (30) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
hw/rtl/tym_pkg.sv
hw/rtl/tym_div.sv
hw/rtl/two_thruster_yaw_mixer.sv
hw/rtl/tym_checker.sv
tb/thrust_mix_checker.sv
tb/tb.sv
